// File: design/stbs_pkg.sv
// ----------------------------------------------------------------------------
// stbs_pkg
// Shared types, constants and helpers for the sorted table search unit.
// ----------------------------------------------------------------------------
package stbs_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int IDX_W       = 4;
  localparam int CNT_W       = 5;
  localparam int DATA_W      = 32;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = 1;

  localparam logic KIND_WRITE  = 1'b0;
  localparam logic KIND_SEARCH = 1'b1;

  typedef enum logic [1:0] {
    OP_WRITE,
    OP_SEARCH,
    OP_MISS
  } op_t;

  typedef struct packed {
    op_t                      op;
    logic [IDX_W-1:0]         addr;
    logic signed [DATA_W-1:0] data;
    logic [CNT_W-1:0]         cnt;
  } req_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_PROBE,
    ST_RESULT
  } back_state_t;

  // midpoint of the window [lo, hi), i.e. (left + right) / 2 with right = hi - 1
  function automatic logic [IDX_W-1:0] mid_of(input logic [CNT_W-1:0] lo,
                                              input logic [CNT_W-1:0] hi);
    logic [CNT_W:0] s;
    s = {1'b0, lo} + {1'b0, hi} - (CNT_W+1)'(1);
    return s[IDX_W:1];
  endfunction

endpackage

// File: design/stbs_front.sv
// ----------------------------------------------------------------------------
// stbs_front
// Accepts requests, holds the entry count and classifies each request.
// ----------------------------------------------------------------------------
module stbs_front import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     entry_count_we,
  input  logic [CNT_W-1:0]         entry_count_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] entry_value,
  input  logic signed [DATA_W-1:0] search_key,
  output logic                     push_valid,
  input  logic                     push_ready,
  output req_t                     push_req
);

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(TABLE_DEPTH);

  logic [CNT_W-1:0] entry_count;
  logic [CNT_W-1:0] cnt_sat;
  logic             stage_valid;
  req_t             stage_req;
  req_t             req_next;

  assign in_ready   = !stage_valid || push_ready;
  assign push_valid = stage_valid;
  assign push_req   = stage_req;

  always_comb begin
    cnt_sat = (entry_count > DEPTH_CNT) ? DEPTH_CNT : entry_count;
    req_next.addr = entry_index;
    req_next.cnt  = cnt_sat;
    if (kind == KIND_SEARCH) begin
      req_next.data = search_key;
      // empty table answers without touching the memory
      req_next.op   = (cnt_sat == '0) ? OP_MISS : OP_SEARCH;
    end else begin
      req_next.data = entry_value;
      req_next.op   = OP_WRITE;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
      stage_valid <= 1'b0;
    end else begin
      if (entry_count_we) begin
        entry_count <= entry_count_wdata;
      end
      if (in_ready) begin
        stage_valid <= in_valid;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      stage_req <= req_next;
    end
  end

endmodule

// File: design/stbs_queue.sv
// ----------------------------------------------------------------------------
// stbs_queue
// Short request queue between the front and back parts.
// ----------------------------------------------------------------------------
module stbs_queue import stbs_pkg::*; (
  input  logic  clk,
  input  logic  rst,
  input  logic  push_valid,
  output logic  push_ready,
  input  req_t  push_req,
  output logic  pop_valid,
  input  logic  pop_ready,
  output req_t  pop_req
);

  req_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign push_ready = (fill != (QPTR_W+1)'(QUEUE_DEPTH));
  assign pop_valid  = (fill != '0);
  assign pop_req    = slots[rd_ptr];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      if (do_push && !do_pop) begin
        fill <= fill + (QPTR_W+1)'(1);
      end else if (do_pop && !do_push) begin
        fill <= fill - (QPTR_W+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_req;
    end
  end

endmodule

// File: design/stbs_back.sv
// ----------------------------------------------------------------------------
// stbs_back
// Table memory and probe sequencer; one probe per cycle, registered result.
// ----------------------------------------------------------------------------
module stbs_back import stbs_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             q_valid,
  output logic             q_ready,
  input  req_t             q_req,
  output logic             out_valid,
  input  logic             out_ready,
  output logic             found,
  output logic [IDX_W-1:0] position
);

  logic signed [DATA_W-1:0] entry_mem [TABLE_DEPTH];
  logic signed [DATA_W-1:0] rdata;
  logic [IDX_W-1:0]         rd_addr;
  logic                     mem_we;

  back_state_t              state;
  back_state_t              state_next;
  logic signed [DATA_W-1:0] key;
  logic signed [DATA_W-1:0] key_next;
  logic [CNT_W-1:0]         left;
  logic [CNT_W-1:0]         left_next;
  logic [CNT_W-1:0]         hi;
  logic [CNT_W-1:0]         hi_next;
  logic [IDX_W-1:0]         probe_idx;
  logic                     res_found;
  logic                     res_found_next;
  logic [IDX_W-1:0]         res_pos;
  logic [IDX_W-1:0]         res_pos_next;
  logic                     out_load;

  always_comb begin
    state_next     = state;
    key_next       = key;
    left_next      = left;
    hi_next        = hi;
    res_found_next = res_found;
    res_pos_next   = res_pos;
    rd_addr        = mid_of(left, hi);
    q_ready        = 1'b0;
    mem_we         = 1'b0;
    out_load       = 1'b0;
    case (state)
      ST_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_req.op)
            OP_WRITE: begin
              mem_we = 1'b1;
            end
            OP_SEARCH: begin
              key_next   = q_req.data;
              left_next  = '0;
              hi_next    = q_req.cnt;
              rd_addr    = mid_of('0, q_req.cnt);
              state_next = ST_PROBE;
            end
            default: begin
              res_found_next = 1'b0;
              res_pos_next   = '0;
              state_next     = ST_RESULT;
            end
          endcase
        end
      end
      ST_PROBE: begin
        if (rdata == key) begin
          res_found_next = 1'b1;
          res_pos_next   = probe_idx;
          state_next     = ST_RESULT;
        end else begin
          if (rdata > key) begin
            hi_next = {1'b0, probe_idx};
          end else begin
            left_next = {1'b0, probe_idx} + CNT_W'(1);
          end
          if (left_next < hi_next) begin
            // next address goes straight to the memory, no bubble
            rd_addr = mid_of(left_next, hi_next);
          end else begin
            res_found_next = 1'b0;
            res_pos_next   = '0;
            state_next     = ST_RESULT;
          end
        end
      end
      ST_RESULT: begin
        if (!out_valid || out_ready) begin
          out_load   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    key       <= key_next;
    left      <= left_next;
    hi        <= hi_next;
    probe_idx <= rd_addr;
    res_found <= res_found_next;
    res_pos   <= res_pos_next;
    if (out_load) begin
      found    <= res_found;
      position <= res_pos;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      entry_mem[q_req.addr] <= q_req.data;
    end
    rdata <= entry_mem[rd_addr];
  end

endmodule

// File: design/sorted_table_binary_search_unit.sv
// ----------------------------------------------------------------------------
// sorted_table_binary_search_unit
// Binary search over a software-filled ascending table of signed entries.
//
//   channel      | handshake                      | carries
//   request in   | in_valid / in_ready            | kind, entry_index, entry_value,
//                |                                | search_key
//   result out   | out_valid / out_ready          | found, position
//   count write  | entry_count_we                 | entry_count_wdata
//
// a search passes the front stage, the queue, the first address issue and p
// probes (at most 5 for a 16-entry table, none for an empty one), one probe per
// cycle from the registered table read, then the registered result
// a write request reaches the table from the queue once the back part is idle
// reset clears the count, queue and control; table contents stay unknown
// a held result stalls the back part only; front and queue keep taking
// requests until the queue and the front stage are full
// ----------------------------------------------------------------------------
module sorted_table_binary_search_unit import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     entry_count_we,
  input  logic [CNT_W-1:0]         entry_count_wdata,
  input  logic                     in_valid,
  output logic                     in_ready,
  input  logic                     kind,
  input  logic [IDX_W-1:0]         entry_index,
  input  logic signed [DATA_W-1:0] entry_value,
  input  logic signed [DATA_W-1:0] search_key,
  output logic                     out_valid,
  input  logic                     out_ready,
  output logic                     found,
  output logic [IDX_W-1:0]         position
);

  logic push_valid;
  logic push_ready;
  req_t push_req;
  logic q_valid;
  logic q_ready;
  req_t q_req;

  stbs_front u_front (
    .clk               (clk),
    .rst               (rst),
    .entry_count_we    (entry_count_we),
    .entry_count_wdata (entry_count_wdata),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .kind              (kind),
    .entry_index       (entry_index),
    .entry_value       (entry_value),
    .search_key        (search_key),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_req          (push_req)
  );

  stbs_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_req   (push_req),
    .pop_valid  (q_valid),
    .pop_ready  (q_ready),
    .pop_req    (q_req)
  );

  stbs_back u_back (
    .clk       (clk),
    .rst       (rst),
    .q_valid   (q_valid),
    .q_ready   (q_ready),
    .q_req     (q_req),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .found     (found),
    .position  (position)
  );

endmodule

// File: design/stbs_checker.sv
// ----------------------------------------------------------------------------
// stbs_checker
// Port-level checks on the search unit results.
// ----------------------------------------------------------------------------
module stbs_checker import stbs_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     entry_count_we,
  input  logic [CNT_W-1:0]         entry_count_wdata,
  input  logic                     out_valid,
  input  logic                     out_ready,
  input  logic                     found,
  input  logic [IDX_W-1:0]         position
);

  logic [CNT_W-1:0] cnt_shadow;

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt_shadow <= '0;
    end else if (entry_count_we) begin
      cnt_shadow <= entry_count_wdata;
    end
  end

  a_reset_idle: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result valid right after reset");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(found) && $stable(position))
    else $error("stalled result changed");

  a_miss_pos: assert property (@(posedge clk) disable iff (rst)
    out_valid && !found |-> position == '0)
    else $error("miss with nonzero position");

  a_empty_miss: assert property (@(posedge clk) disable iff (rst)
    out_valid && cnt_shadow == '0 |-> !found)
    else $error("hit reported on empty table");

  a_hit_range: assert property (@(posedge clk) disable iff (rst)
    out_valid && found |-> {1'b0, position} < cnt_shadow)
    else $error("hit position outside used entries");

endmodule

bind sorted_table_binary_search_unit stbs_checker u_stbs_checker (
  .clk               (clk),
  .rst               (rst),
  .entry_count_we    (entry_count_we),
  .entry_count_wdata (entry_count_wdata),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .found             (found),
  .position          (position)
);
